>>> hw/rtl/deque_with_value_search_defines.svh
// ----------------------------------------------------------------------------
// deque_with_value_search_defines
// assertion macros used by the deque top rtl file
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_VALUE_SEARCH_DEFINES_SVH
`define DEQUE_WITH_VALUE_SEARCH_DEFINES_SVH

// same-cycle implication, held off during reset
`define DEQVS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deqvs same-cycle check failed");

// next-cycle implication, held off during reset
`define DEQVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deqvs next-cycle check failed");

`endif

>>> hw/rtl/deqvs_pkg.sv
// ----------------------------------------------------------------------------
// deqvs_pkg
// types and codes of the deque with value search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deqvs_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int POS_W           = 5;

    // request kinds
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_SEARCH     = 3'd4;
    localparam logic [2:0] KIND_DUMP       = 3'd5;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [POS_W-1:0]   position;
        logic               last;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DUMP
    } t_state;

    // operation applied to every cell of the chain at once
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        logic valid;
        logic tail;
    } t_cell_flags;

endpackage

`default_nettype wire

>>> hw/rtl/deqvs_cell.sv
// ----------------------------------------------------------------------------
// deqvs_cell
// one storage cell of the deque chain, trades data with its neighbors
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deqvs_cell
    import deqvs_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire t_cell_op                 i_op,
    input  wire logic [VALUE_WIDTH-1:0]   i_prev_data,
    input  wire logic                     i_prev_valid,
    input  wire logic [VALUE_WIDTH-1:0]   i_next_data,
    input  wire logic                     i_next_valid,
    input  wire logic [VALUE_WIDTH-1:0]   i_head_data,
    input  wire logic [VALUE_WIDTH-1:0]   i_new_data,
    output logic [VALUE_WIDTH-1:0]        o_data,
    output t_cell_flags                   o_flags
);

    logic [VALUE_WIDTH-1:0] r_data;
    logic [VALUE_WIDTH-1:0] n_data;
    logic                   r_valid;
    logic                   n_valid;
    logic                   w_tail;
    logic                   w_first_free;

    assign w_tail       = r_valid && !i_next_valid;
    assign w_first_free = !r_valid && i_prev_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        unique case (i_op)
            OP_HOLD: begin
            end
            OP_PUSH_FRONT: begin
                n_data  = i_prev_data;
                n_valid = i_prev_valid;
            end
            OP_PUSH_BACK: begin
                if (w_first_free) begin
                    n_data  = i_new_data;
                    n_valid = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                n_data  = i_next_data;
                n_valid = i_next_valid;
            end
            OP_POP_BACK: begin
                if (w_tail) begin
                    n_valid = 1'b0;
                end
            end
            OP_ROTATE: begin
                // head value wraps around to the tail
                n_data = w_tail ? i_head_data : i_next_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data        = r_data;
    assign o_flags.valid = r_valid;
    assign o_flags.tail  = w_tail;

endmodule

`default_nettype wire

>>> hw/rtl/deqvs_chain.sv
// ----------------------------------------------------------------------------
// deqvs_chain
// row of deque cells, front at cell 0, with head and tail taps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deqvs_chain
    import deqvs_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire t_cell_op                 i_op,
    input  wire logic [VALUE_WIDTH-1:0]   i_new_data,
    output logic [VALUE_WIDTH-1:0]        o_head_data,
    output logic                          o_head_valid,
    output logic [VALUE_WIDTH-1:0]        o_tail_data
);

    logic [VALUE_WIDTH-1:0] w_data  [DEPTH];
    t_cell_flags            w_flags [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_prev_data;
        logic                   w_prev_valid;
        logic [VALUE_WIDTH-1:0] w_next_data;
        logic                   w_next_valid;

        if (g == 0) begin : g_first
            // new value enters at the front on push front
            assign w_prev_data  = i_new_data;
            assign w_prev_valid = 1'b1;
        end else begin : g_mid
            assign w_prev_data  = w_data[g-1];
            assign w_prev_valid = w_flags[g-1].valid;
        end

        if (g == DEPTH - 1) begin : g_end
            assign w_next_data  = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_data  = w_data[g+1];
            assign w_next_valid = w_flags[g+1].valid;
        end

        deqvs_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (i_op),
            .i_prev_data  (w_prev_data),
            .i_prev_valid (w_prev_valid),
            .i_next_data  (w_next_data),
            .i_next_valid (w_next_valid),
            .i_head_data  (w_data[0]),
            .i_new_data   (i_new_data),
            .o_data       (w_data[g]),
            .o_flags      (w_flags[g])
        );
    end

    // exactly one cell flags tail when the list is not empty
    always_comb begin
        o_tail_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_flags[k].tail) begin
                o_tail_data = o_tail_data | w_data[k];
            end
        end
    end

    assign o_head_data  = w_data[0];
    assign o_head_valid = w_flags[0].valid;

endmodule

`default_nettype wire

>>> hw/rtl/deque_with_value_search.sv
// ----------------------------------------------------------------------------
// deque_with_value_search
// bounded double-ended queue of signed values with search and dump
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carry one request word (kind, value)
//   output channel: o_out_valid / i_out_stall carry result words
//   push and pop load their single result word at the edge that takes the
//   request, so it shows in the next cycle and a new request may enter then
//   search rotates the cell chain once over the N held entries and loads its
//   single result word on the final step
//   dump rotates the chain the same way and emits one word per cycle while
//   the receiver does not stall, front to back, with last set on the final
//   entry; an empty list gives one word
//   requests of an unknown kind are taken and dropped without a result
//   reset empties the list; cell contents are not cleared
//   while the receiver stalls the output word holds and o_in_stall stays high;
//   a dump stops rotating, a search walks on and waits at its final step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "deque_with_value_search_defines.svh"

module deque_with_value_search
    import deqvs_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire t_in_word  i_in_word,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_word      o_out_word,
    input  wire            i_out_stall
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STEP_W = $clog2(DEPTH);
    localparam int PX_W   = (STEP_W + 1 > POS_W) ? STEP_W + 1 : POS_W;

    // control state
    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic                r_found;
    logic                n_found;
    logic [POS_W-1:0]    r_fpos;
    logic [POS_W-1:0]    n_fpos;
    logic signed [VALUE_WIDTH-1:0] r_key;
    logic signed [VALUE_WIDTH-1:0] n_key;

    // output register
    logic                r_out_valid;
    t_out_word           r_out_word;
    logic                w_load;
    t_out_word           w_word;

    // datapath
    t_cell_op            w_op;
    logic                w_in_acc;
    logic                w_can_load;
    logic                w_empty;
    logic                w_full;
    logic                w_last_step;
    logic                w_match;
    logic [2:0]          w_kind;
    logic signed [VALUE_WIDTH-1:0] w_in_val;
    logic signed [VALUE_WIDTH-1:0] w_head_data;
    logic signed [VALUE_WIDTH-1:0] w_tail_data;
    logic                w_head_valid;
    logic [PX_W-1:0]     w_pos_ext;
    logic [POS_W-1:0]    w_pos;

    // check helpers
    logic                w_busy;
    logic                w_push_ok;

    deqvs_chain #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_op),
        .i_new_data   (w_in_val),
        .o_head_data  (w_head_data),
        .o_head_valid (w_head_valid),
        .o_tail_data  (w_tail_data)
    );

    // handshake: output register frees when empty or being taken
    assign w_can_load = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && w_can_load);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // request value kept at the store width, sign carried along
    assign w_kind   = i_in_word.kind;
    assign w_in_val = VALUE_WIDTH'(i_in_word.value);

    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_last_step = (r_step == STEP_W'(r_count - 1'b1));
    assign w_match     = (w_head_data == r_key);

    // 1-based position of the head entry during a walk, low bits only
    assign w_pos_ext = PX_W'(r_step) + PX_W'(1);
    assign w_pos     = w_pos_ext[POS_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && !w_empty) begin
                    if (w_kind == KIND_SEARCH) begin
                        n_state = ST_SEARCH;
                    end else if (w_kind == KIND_DUMP) begin
                        n_state = ST_DUMP;
                    end
                end
            end
            ST_SEARCH, ST_DUMP: begin
                if (w_last_step && w_can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // chain operation, counters and result word
    always_comb begin
        w_op    = OP_HOLD;
        w_load  = 1'b0;
        w_word  = '0;
        n_count = r_count;
        n_step  = r_step;
        n_found = r_found;
        n_fpos  = r_fpos;
        n_key   = r_key;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_kind)
                        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                            w_load           = 1'b1;
                            w_word.value_out = 32'(w_in_val);
                            w_word.last      = 1'b1;
                            if (w_full) begin
                                w_word.status = STATUS_FULL;
                            end else begin
                                w_word.status = STATUS_OK;
                                w_op    = (w_kind == KIND_PUSH_FRONT) ? OP_PUSH_FRONT
                                                                      : OP_PUSH_BACK;
                                n_count = r_count + 1'b1;
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_BACK: begin
                            w_load      = 1'b1;
                            w_word.last = 1'b1;
                            if (w_empty) begin
                                w_word.status = STATUS_EMPTY;
                            end else begin
                                w_word.status = STATUS_OK;
                                if (w_kind == KIND_POP_FRONT) begin
                                    w_op             = OP_POP_FRONT;
                                    w_word.value_out = 32'(w_head_data);
                                end else begin
                                    w_op             = OP_POP_BACK;
                                    w_word.value_out = 32'(w_tail_data);
                                end
                                n_count = r_count - 1'b1;
                            end
                        end
                        KIND_SEARCH: begin
                            if (w_empty) begin
                                w_load           = 1'b1;
                                w_word.status    = STATUS_EMPTY;
                                w_word.value_out = 32'(w_in_val);
                                w_word.last      = 1'b1;
                            end else begin
                                n_key   = w_in_val;
                                n_step  = '0;
                                n_found = 1'b0;
                                n_fpos  = '0;
                            end
                        end
                        KIND_DUMP: begin
                            if (w_empty) begin
                                w_load        = 1'b1;
                                w_word.status = STATUS_EMPTY;
                                w_word.last   = 1'b1;
                            end else begin
                                n_step = '0;
                            end
                        end
                        default: begin
                            // unknown kind: dropped
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // full rotation restores the order; result waits for a free slot
                if (w_can_load || !w_last_step) begin
                    w_op   = OP_ROTATE;
                    n_step = r_step + 1'b1;
                    if (w_match && !r_found) begin
                        n_found = 1'b1;
                        n_fpos  = w_pos;
                    end
                    if (w_last_step) begin
                        w_load           = 1'b1;
                        w_word.value_out = 32'(r_key);
                        w_word.last      = 1'b1;
                        if (r_found) begin
                            w_word.status   = STATUS_OK;
                            w_word.position = r_fpos;
                        end else if (w_match) begin
                            w_word.status   = STATUS_OK;
                            w_word.position = w_pos;
                        end else begin
                            w_word.status = STATUS_NOTFOUND;
                        end
                    end
                end
            end
            ST_DUMP: begin
                // one entry per cycle from the head while the output slot is free
                if (w_can_load) begin
                    w_op             = OP_ROTATE;
                    n_step           = r_step + 1'b1;
                    w_load           = 1'b1;
                    w_word.status    = STATUS_OK;
                    w_word.value_out = 32'(w_head_data);
                    w_word.position  = w_pos;
                    w_word.last      = w_last_step;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_found <= n_found;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_fpos <= n_fpos;
        if (w_load) begin
            r_out_word <= w_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // checks
    assign w_busy    = (r_state != ST_IDLE);
    assign w_push_ok = w_in_acc && !w_full &&
                       ((w_kind == KIND_PUSH_FRONT) || (w_kind == KIND_PUSH_BACK));

    `DEQVS_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `DEQVS_ASSERT_IMPL(a_head_matches_count, i_clk, i_rst_n, 1'b1, w_head_valid == !w_empty)
    `DEQVS_ASSERT_IMPL(a_walk_in_range, i_clk, i_rst_n, w_busy, CNT_W'(r_step) < r_count)
    `DEQVS_ASSERT_IMPL(a_busy_stalls_input, i_clk, i_rst_n, w_busy, o_in_stall)
    `DEQVS_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_push_ok, r_count == $past(r_count) + 1'b1)

endmodule

`default_nettype wire
